// File: hw/rtl/mi3_pkg.sv
`default_nettype none
package mi3_pkg;

  localparam int FRAC_BITS = 16;

  localparam int EW    = 32;                // matrix entry width
  localparam int CW    = 64;                // cofactor width (always fits signed 64)
  localparam int DW    = 98;                // exact determinant width
  localparam int MAGW  = 97;                // determinant magnitude width
  localparam int DENW  = MAGW + 1;          // divisor is twice the magnitude
  localparam int NW0   = 2 * FRAC_BITS + CW + 1;
  localparam int NW    = ((NW0 > MAGW) ? NW0 : MAGW) + 1;
  localparam int QB    = 33;                // quotient bits resolved by each lane
  localparam int XW    = NW + QB;
  localparam int THRW  = 31;
  localparam int RW    = 32;                // inverse entry width
  localparam int DVW   = 64;                // det_value width

  localparam int FRONT_LAT = 6;
  localparam int LANE_LAT  = QB + 2;
  localparam int NLANE     = 9;

  typedef logic [3:0] idx_t;

  // Cofactor i is e[IP]*e[IT] - e[IQ]*e[IS], row-major over the adjugate.
  localparam idx_t IP [NLANE] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam idx_t IT [NLANE] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam idx_t IQ [NLANE] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam idx_t IS [NLANE] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  typedef struct packed {
    logic signed [EW-1:0] a11;
    logic signed [EW-1:0] a12;
    logic signed [EW-1:0] a13;
    logic signed [EW-1:0] a21;
    logic signed [EW-1:0] a22;
    logic signed [EW-1:0] a23;
    logic signed [EW-1:0] a31;
    logic signed [EW-1:0] a32;
    logic signed [EW-1:0] a33;
  } mat_in_t;

  typedef struct packed {
    logic signed [RW-1:0]  inv11;
    logic signed [RW-1:0]  inv12;
    logic signed [RW-1:0]  inv13;
    logic signed [RW-1:0]  inv21;
    logic signed [RW-1:0]  inv22;
    logic signed [RW-1:0]  inv23;
    logic signed [RW-1:0]  inv31;
    logic signed [RW-1:0]  inv32;
    logic signed [RW-1:0]  inv33;
    logic signed [DVW-1:0] det_value;
    logic                  singular;
    logic                  pos_definite;
  } res_out_t;

  typedef struct packed {
    logic [NW-1:0] num;
    logic          rneg;
  } lane_op_t;

  typedef struct packed {
    logic signed [DVW-1:0] det_value;
    logic                  singular;
    logic                  pos_definite;
  } side_t;

endpackage
`default_nettype wire

// File: hw/rtl/matrix3x3_inverse_determinant.sv
`default_nettype none
// Channel   Handshake                  Payload
// input     start / busy               in_data  (mat_in_t)
// result    out_strobe                 out_data (res_out_t)
// config    psel penable pwrite pready paddr pwdata prdata
//
// One item is taken every cycle; busy is always low. Each result is on the
// outputs after its item has passed the input register, six front stages, and
// nine divider lanes of one stage per quotient bit plus two more.
// The lane dividers set both the latency and the one-item-per-cycle rate.
// Reset clears the valid pipeline and sets singular_threshold to 1.
// Results are shown for one cycle and cannot be held off.
module matrix3x3_inverse_determinant import mi3_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire mat_in_t     in_data,
  output logic             out_strobe,
  output res_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int LAT = 1 + FRONT_LAT + LANE_LAT;

  logic [THRW-1:0]  thr_r;
  mat_in_t          mat_r;
  logic [LAT-1:0]   vld_r;
  side_t            side_r [LANE_LAT];

  lane_op_t               op_w [NLANE];
  logic [DENW-1:0]        den_w;
  side_t                  side_w;
  logic signed [RW-1:0]   res_w [NLANE];
  logic                   accept;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRW'(1);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      thr_r <= pwdata[THRW-1:0];
    end
  end

  assign prdata = paddr[2] ? '0 : {1'b0, thr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    mat_r     <= in_data;
    side_r[0] <= side_w;
    for (int k = 1; k < LANE_LAT; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  mi3_front u_front (
    .clk  (clk),
    .mat  (mat_r),
    .thr  (thr_r),
    .op   (op_w),
    .den  (den_w),
    .side (side_w)
  );

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    mi3_lane u_lane (
      .clk  (clk),
      .op   (op_w[g]),
      .den  (den_w),
      .zero (side_w.singular),
      .res  (res_w[g])
    );
  end

  // Merge the nine lane results with the delayed determinant and flags.
  assign out_strobe             = vld_r[LAT-1];
  assign out_data.inv11         = res_w[0];
  assign out_data.inv12         = res_w[1];
  assign out_data.inv13         = res_w[2];
  assign out_data.inv21         = res_w[3];
  assign out_data.inv22         = res_w[4];
  assign out_data.inv23         = res_w[5];
  assign out_data.inv31         = res_w[6];
  assign out_data.inv32         = res_w[7];
  assign out_data.inv33         = res_w[8];
  assign out_data.det_value     = side_r[LANE_LAT-1].det_value;
  assign out_data.singular      = side_r[LANE_LAT-1].singular;
  assign out_data.pos_definite  = side_r[LANE_LAT-1].pos_definite;

endmodule
`default_nettype wire

// File: hw/rtl/mi3_lane.sv
`default_nettype none
module mi3_lane import mi3_pkg::*; (
  input  wire logic             clk,
  input  wire lane_op_t         op,
  input  wire logic [DENW-1:0]  den,
  input  wire logic             zero,
  output logic signed [RW-1:0]  res
);

  logic [XW-1:0]   rem_r  [QB+1];
  logic [DENW-1:0] den_r  [QB+1];
  logic [QB-1:0]   q_r    [QB+1];
  logic            rneg_r [QB+1];
  logic            zero_r [QB+1];
  logic            ovf_r  [QB+1];
  logic signed [RW-1:0] res_r;

  logic [XW-1:0] shd [1:QB];
  logic          ge  [1:QB];
  logic          ovf_nxt;
  logic [QB-1:0] qf;

  // A quotient that needs more than QB bits saturates in any case.
  assign ovf_nxt = XW'(op.num) >= (XW'(den) << QB);

  always_comb begin
    for (int k = 1; k <= QB; k++) begin
      shd[k] = XW'(den_r[k-1]) << (QB - k);
      ge[k]  = rem_r[k-1] >= shd[k];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= XW'(op.num);
    den_r[0]  <= den;
    q_r[0]    <= '0;
    rneg_r[0] <= op.rneg;
    zero_r[0] <= zero;
    ovf_r[0]  <= ovf_nxt;
    for (int k = 1; k <= QB; k++) begin
      rem_r[k]  <= ge[k] ? (rem_r[k-1] - shd[k]) : rem_r[k-1];
      q_r[k]    <= q_r[k-1] | (ge[k] ? (QB'(1) << (QB - k)) : '0);
      den_r[k]  <= den_r[k-1];
      rneg_r[k] <= rneg_r[k-1];
      zero_r[k] <= zero_r[k-1];
      ovf_r[k]  <= ovf_r[k-1];
    end
  end

  assign qf = q_r[QB];

  always_ff @(posedge clk) begin
    if (zero_r[QB]) begin
      res_r <= '0;
    end else if (rneg_r[QB]) begin
      if (ovf_r[QB] || qf > QB'(64'h8000_0000)) begin
        res_r <= RW'(33'h0_8000_0000);
      end else begin
        res_r <= -qf[RW-1:0];
      end
    end else begin
      if (ovf_r[QB] || qf > QB'(64'h7FFF_FFFF)) begin
        res_r <= RW'(33'h0_7FFF_FFFF);
      end else begin
        res_r <= qf[RW-1:0];
      end
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// File: hw/rtl/mi3_front.sv
`default_nettype none
module mi3_front import mi3_pkg::*; (
  input  wire logic             clk,
  input  wire mat_in_t          mat,
  input  wire logic [THRW-1:0]  thr,
  output lane_op_t              op [NLANE],
  output logic [DENW-1:0]       den,
  output side_t                 side
);

  logic signed [EW-1:0] e [9];

  assign e[0] = mat.a11;
  assign e[1] = mat.a12;
  assign e[2] = mat.a13;
  assign e[3] = mat.a21;
  assign e[4] = mat.a22;
  assign e[5] = mat.a23;
  assign e[6] = mat.a31;
  assign e[7] = mat.a32;
  assign e[8] = mat.a33;

  // Stage 1: the eighteen 2x2 minor products.
  logic signed [2*EW-1:0] pa_r [NLANE];
  logic signed [2*EW-1:0] pb_r [NLANE];
  logic signed [EW-1:0]   row1_r [3];

  // Stage 2: cofactors.
  logic signed [CW-1:0]   cof_r [NLANE];
  logic signed [EW-1:0]   row2_r [3];

  // Stage 3: row-one expansion split in two 32-bit halves of each cofactor.
  logic signed [EW+32:0]  plo_r [3];
  logic signed [EW+31:0]  phi_r [3];
  logic [CW-1:0]          acof3_r [NLANE];
  logic                   cneg3_r [NLANE];
  logic                   a0pos3_r, m2pos3_r;

  // Stage 4: exact determinant.
  logic signed [DW-1:0]   det_r;
  logic [CW-1:0]          acof4_r [NLANE];
  logic                   cneg4_r [NLANE];
  logic                   a0pos4_r, m2pos4_r;

  // Stage 5: magnitude and Q48.16 determinant.
  logic [MAGW-1:0]        mag_r;
  logic                   neg5_r, zero5_r, a0pos5_r, m2pos5_r;
  logic signed [DVW-1:0]  dval5_r;
  logic [CW-1:0]          acof5_r [NLANE];
  logic                   cneg5_r [NLANE];

  // Stage 6: lane operands.
  lane_op_t               op_r [NLANE];
  logic [DENW-1:0]        den_r;
  side_t                  side_r;

  logic signed [DW-1:0]   det_sum;
  logic signed [DW-1:0]   vsh;
  logic                   vfits;

  always_comb begin
    det_sum = '0;
    for (int j = 0; j < 3; j++) begin
      det_sum = det_sum + DW'(plo_r[j]) + (DW'(phi_r[j]) <<< 32);
    end
  end

  assign vsh   = det_r >>> (2 * FRAC_BITS);
  assign vfits = (&vsh[DW-1:DVW-1]) || !(|vsh[DW-1:DVW-1]);

  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      pa_r[i] <= e[IP[i]] * e[IT[i]];
      pb_r[i] <= e[IQ[i]] * e[IS[i]];
      cof_r[i] <= pa_r[i] - pb_r[i];
      acof3_r[i] <= cof_r[i][CW-1] ? CW'(-cof_r[i]) : CW'(cof_r[i]);
      cneg3_r[i] <= cof_r[i][CW-1];
      acof4_r[i] <= acof3_r[i];
      cneg4_r[i] <= cneg3_r[i];
      acof5_r[i] <= acof4_r[i];
      cneg5_r[i] <= cneg4_r[i];
      op_r[i].num  <= (NW'(acof5_r[i]) << (2 * FRAC_BITS + 1)) + NW'(mag_r);
      op_r[i].rneg <= cneg5_r[i] ^ neg5_r;
    end
    for (int j = 0; j < 3; j++) begin
      row1_r[j] <= e[j];
      row2_r[j] <= row1_r[j];
      plo_r[j]  <= row2_r[j] * $signed({1'b0, cof_r[3*j][31:0]});
      phi_r[j]  <= row2_r[j] * $signed(cof_r[3*j][CW-1:32]);
    end
    a0pos3_r <= row2_r[0] > 0;
    m2pos3_r <= !cof_r[8][CW-1] && (cof_r[8] != '0);

    det_r    <= det_sum;
    a0pos4_r <= a0pos3_r;
    m2pos4_r <= m2pos3_r;

    mag_r    <= det_r[DW-1] ? MAGW'(-det_r) : MAGW'(det_r);
    neg5_r   <= det_r[DW-1];
    zero5_r  <= det_r == '0;
    a0pos5_r <= a0pos4_r;
    m2pos5_r <= m2pos4_r;
    if (vfits) begin
      dval5_r <= vsh[DVW-1:0];
    end else if (det_r[DW-1]) begin
      dval5_r <= {1'b1, {(DVW-1){1'b0}}};
    end else begin
      dval5_r <= {1'b0, {(DVW-1){1'b1}}};
    end

    den_r                <= {mag_r, 1'b0};
    side_r.det_value     <= dval5_r;
    side_r.singular      <= zero5_r || (mag_r < (MAGW'(thr) << (2 * FRAC_BITS)));
    side_r.pos_definite  <= a0pos5_r && m2pos5_r && !neg5_r && !zero5_r;
  end

  assign op   = op_r;
  assign den  = den_r;
  assign side = side_r;

endmodule
`default_nettype wire
